[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cab_pkg.sv]
// ---------------------------------------------------------------------------
// cab_pkg
// Types, constants and helpers shared by the clipped alpha blend pipeline.
// ---------------------------------------------------------------------------
package cab_pkg;

  localparam int MaxCanvasDim = 4096;
  localparam int DimW         = 13;
  localparam int CoordW       = 12;
  localparam int AddrW        = 24;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 13;

  localparam logic [7:0] AlphaOpaque = 8'hff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CANVAS_WIDTH  = 3'd0,
    CFG_CANVAS_HEIGHT = 3'd1,
    CFG_DEST_X        = 3'd2,
    CFG_DEST_Y        = 3'd3,
    CFG_LAYER_ALPHA   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]       source_pixel;
    logic [31:0]       canvas_pixel;
    logic [CoordW-1:0] image_column;
    logic [CoordW-1:0] image_row;
  } in_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] canvas_address;
    logic [31:0]      blended_pixel;
  } out_t;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } ctl_t;

  // Exact x / 255 for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    return (d > DimW'(MaxCanvasDim)) ? DimW'(MaxCanvasDim) : d;
  endfunction

endpackage

[design/clipped_alpha_blend.sv]
// ---------------------------------------------------------------------------
// clipped_alpha_blend
// Alpha-over blend of one ARGB 8888 source pixel onto a clipped canvas.
// ---------------------------------------------------------------------------
// Usage: each input request carries a source pixel, the canvas pixel under it
// and the pixel's column and row inside the image. A request is taken at a
// rising edge with in_valid_i high and in_stall_o low; a result request leaves
// at an edge with out_valid_o high and out_stall_i low. Every input request
// gives exactly one result request, in order.
// The pipeline takes one request per cycle while out_stall_i is low, through
// four register stages (position and alpha product, address multiply and alpha
// divide, channel products, output register).
// When the receiver stalls, the output register holds its request and stages
// behind it keep filling until the first full stage; in_stall_o rises only when
// stage one is occupied and cannot move on.
// The user must write registers over the cfg port (always ready) only while
// the pipeline is empty; the block does not enforce this. Reset empties the
// pipeline and loads a 640 x 480 canvas, a zero offset and an opaque layer alpha.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_alpha_blend import cab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [DimW-1:0] canvas_width_q, canvas_height_q, dest_x_q, dest_y_q;
  logic [7:0]      layer_alpha_q;

  // Stage valid bits and handshake.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  ctl_t ctl;

  logic              geom_inr;
  logic [AddrW-1:0]  geom_addr;
  logic              blend_anz;
  logic [31:0]       blend_pix;
  out_t              out_d, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= DimW'(640);
      canvas_height_q <= DimW'(480);
      dest_x_q        <= '0;
      dest_y_q        <= '0;
      layer_alpha_q   <= AlphaOpaque;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data_i;
        CFG_DEST_X:        dest_x_q        <= cfg_data_i;
        CFG_DEST_Y:        dest_y_q        <= cfg_data_i;
        CFG_LAYER_ALPHA:   layer_alpha_q   <= cfg_data_i[7:0];
        default:           ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on this cycle, so
  // bubbles close up behind a stalled output.
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ctl.en1 = rdy1;
  assign ctl.en2 = rdy2;
  assign ctl.en3 = rdy3;
  assign ctl.en4 = rdy4;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  cab_geom u_geom (
    .clk_i           (clk_i),
    .ctl_i           (ctl),
    .canvas_width_i  (canvas_width_q),
    .canvas_height_i (canvas_height_q),
    .dest_x_i        (dest_x_q),
    .dest_y_i        (dest_y_q),
    .image_column_i  (in_data_i.image_column),
    .image_row_i     (in_data_i.image_row),
    .in_range_o      (geom_inr),
    .addr_o          (geom_addr)
  );

  cab_blend u_blend (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .layer_alpha_i  (layer_alpha_q),
    .source_pixel_i (in_data_i.source_pixel),
    .canvas_pixel_i (in_data_i.canvas_pixel),
    .alpha_nz_o     (blend_anz),
    .pixel_o        (blend_pix)
  );

  // A clipped or fully transparent pixel reports no write and zero fields.
  always_comb begin
    out_d.write_enable   = geom_inr && blend_anz;
    out_d.canvas_address = out_d.write_enable ? geom_addr : '0;
    out_d.blended_pixel  = out_d.write_enable ? blend_pix : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  `CAB_ASSERT_IMPL(a_nowrite_zero, out_valid_o && !out_data_o.write_enable, out_data_o.canvas_address == '0 && out_data_o.blended_pixel == '0, "non-write result has non-zero fields")
  `CAB_ASSERT_IMPL(a_write_opaque, out_valid_o && out_data_o.write_enable, out_data_o.blended_pixel[31:24] == AlphaOpaque, "written pixel is not opaque")
  `CAB_ASSERT_NEXT(a_stage1_held, v1_q && !rdy2, v1_q, "stage one request lost while blocked")
  `CAB_ASSERT_IMPL(a_stall_only_full, !v1_q, !in_stall_o, "input stalled with stage one empty")

endmodule

[design/cab_geom.sv]
// ---------------------------------------------------------------------------
// cab_geom
// Target position, clip test and canvas address over three stages.
// ---------------------------------------------------------------------------
module cab_geom import cab_pkg::*; (
  input  logic              clk_i,
  input  ctl_t              ctl_i,
  input  logic [DimW-1:0]   canvas_width_i,
  input  logic [DimW-1:0]   canvas_height_i,
  input  logic [DimW-1:0]   dest_x_i,
  input  logic [DimW-1:0]   dest_y_i,
  input  logic [CoordW-1:0] image_column_i,
  input  logic [CoordW-1:0] image_row_i,
  output logic              in_range_o,
  output logic [AddrW-1:0]  addr_o
);

  logic [DimW-1:0]   w_clamp, h_clamp;
  logic [DimW:0]     tx_s, ty_s;
  logic              inr_d;
  logic [CoordW-1:0] tx_q, ty_q;
  logic              inr1_q, inr2_q, inr3_q;
  logic [2*DimW-1:0] addr_sum;
  logic [AddrW-1:0]  addr2_q, addr3_q;

  assign w_clamp = clamp_dim(canvas_width_i);
  assign h_clamp = clamp_dim(canvas_height_i);

  // Sign-extended offset plus zero-extended image coordinate.
  assign tx_s = {dest_x_i[DimW-1], dest_x_i} + {2'b00, image_column_i};
  assign ty_s = {dest_y_i[DimW-1], dest_y_i} + {2'b00, image_row_i};

  assign inr_d = !tx_s[DimW] && !ty_s[DimW]
              && (tx_s[DimW-1:0] < w_clamp) && (ty_s[DimW-1:0] < h_clamp);

  assign addr_sum = ({{(2*DimW-CoordW){1'b0}}, ty_q} * {{DimW{1'b0}}, w_clamp})
                  + {{(2*DimW-CoordW){1'b0}}, tx_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      tx_q   <= tx_s[CoordW-1:0];
      ty_q   <= ty_s[CoordW-1:0];
      inr1_q <= inr_d;
    end
    if (ctl_i.en2) begin
      addr2_q <= addr_sum[AddrW-1:0];
      inr2_q  <= inr1_q;
    end
    if (ctl_i.en3) begin
      addr3_q <= addr2_q;
      inr3_q  <= inr2_q;
    end
  end

  assign in_range_o = inr3_q;
  assign addr_o     = addr3_q;

endmodule

[design/cab_blend.sv]
// ---------------------------------------------------------------------------
// cab_blend
// Alpha scaling and per-channel blend; the final divide is left combinational
// in front of the output register.
// ---------------------------------------------------------------------------
module cab_blend import cab_pkg::*; (
  input  logic        clk_i,
  input  ctl_t        ctl_i,
  input  logic [7:0]  layer_alpha_i,
  input  logic [31:0] source_pixel_i,
  input  logic [31:0] canvas_pixel_i,
  output logic        alpha_nz_o,
  output logic [31:0] pixel_o
);

  logic [15:0] aprod_q;
  logic [23:0] src1_q, cvs1_q, src2_q, cvs2_q;
  logic [7:0]  a_q;
  logic [15:0] sum_d [3];
  logic [15:0] sum_q [3];
  logic        anz_q;
  logic [15:0] acc;
  logic [7:0]  inv_a;

  assign inv_a = AlphaOpaque - a_q;

  // The two products of a channel always sum to at most 255 * 255.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc = ({8'd0, src2_q[8*i +: 8]} * {8'd0, a_q})
          + ({8'd0, cvs2_q[8*i +: 8]} * {8'd0, inv_a});
      sum_d[i] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      aprod_q <= {8'd0, source_pixel_i[31:24]} * {8'd0, layer_alpha_i};
      src1_q  <= source_pixel_i[23:0];
      cvs1_q  <= canvas_pixel_i[23:0];
    end
    if (ctl_i.en2) begin
      a_q    <= div255(aprod_q);
      src2_q <= src1_q;
      cvs2_q <= cvs1_q;
    end
    if (ctl_i.en3) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_d[i];
      end
      anz_q <= (a_q != 8'd0);
    end
  end

  assign alpha_nz_o = anz_q;
  assign pixel_o    = {AlphaOpaque, div255(sum_q[2]), div255(sum_q[1]), div255(sum_q[0])};

endmodule

[sim/tb_clipped_alpha_blend.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_clipped_alpha_blend
// Self-checking bench for the clipped alpha blend pipeline: a directed table
// of register settings and pixels, then randomised phases, each result checked
// field by field against a table value or the bench's behavioural blend model.
// ---------------------------------------------------------------------------
module tb_clipped_alpha_blend import cab_pkg::*; ();

  // Edges from acceptance to the earliest result handshake.
  localparam int PipeLatency   = 4;
  // Cycles without any handshake before the run is declared hung. The longest
  // legitimate quiet stretch is a long sender gap plus a long receiver stall
  // plus a drain between phases.
  localparam int WatchdogLimit = 2000;
  localparam int ChannelMax    = 255;
  localparam int MaxCoord      = (1 << CoordW) - 1;
  localparam int MaxDimWord    = (1 << DimW) - 1;
  localparam int ItemsPerPhase = 75;
  localparam int RandomPhases  = 6;

  // First register index beyond the list; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(CFG_LAYER_ALPHA) + 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  clipped_alpha_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // The bench's own copy of the register file, updated when a write is taken.
  logic        [DimW-1:0] canvas_w;
  logic        [DimW-1:0] canvas_h;
  logic signed [DimW-1:0] place_x;
  logic signed [DimW-1:0] place_y;
  logic        [7:0]      layer_a;

  // Blends still owed by the block, oldest first.
  out_t pending_blends[$];
  out_t oldest_blend;
  int   mismatches;
  int   quiet_cycles;
  // When set, neither side inserts gaps or stalls.
  bit   steady_flow;

  // One row of the directed table: either a register write or a pixel. The
  // index and data fields mean nothing on pixel rows, and the pixel fields
  // nothing on write rows. Where typed is set, the result is given directly;
  // otherwise it comes from blend_pixel().
  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    in_t                 pixel;
    logic                typed;
    out_t                result;
  } blit_step_t;

  localparam int DirectedSteps = 33;

  // The rows run under the reset settings (640 x 480, no offset, opaque layer)
  // until the first write row.
  blit_step_t directed_steps [DirectedSteps] = '{
    // Opaque source at the origin replaces the canvas pixel outright.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff112233, 32'h00000000, 12'd0, 12'd0},
      1'b1, '{1'b1, 24'd0, 32'hff112233}},
    // Fully transparent source: nothing is written.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'h00abcdef, 32'h12345678, 12'd5, 12'd5},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // One column past the right edge, then one row past the bottom.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff445566, 32'h00000000, 12'd640, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff445566, 32'h00000000, 12'd0, 12'd480},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // Bottom right corner of the default canvas.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff778899, 32'hffffffff, 12'd639, 12'd479},
      1'b1, '{1'b1, 24'd307199, 32'hff778899}},
    // Largest coordinates are far outside.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hffffffff, 32'h00000000, 12'd4095, 12'd4095},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // Partial alphas, including the smallest non-zero one.
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'h80ffffff, 32'h00000000, 12'd1, 12'd0},
      1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'h01000000, 32'hffffffff, 12'd2, 12'd1},
      1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'h7f00ff00, 32'h00ff00ff, 12'd3, 12'd2},
      1'b0, '0},
    // Oversized canvas, treated as the maximum, with the most negative offset.
    '{STEP_WRITE, CFG_CANVAS_WIDTH, 13'd8191, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_CANVAS_HEIGHT, 13'd8191, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_DEST_X, 13'h1000, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff123456, 32'h00000000, 12'd4095, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // Most positive offset: the very last canvas address, then just outside.
    '{STEP_WRITE, CFG_DEST_X, 13'h0fff, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hffaabbcc, 32'h00000000, 12'd0, 12'd4095},
      1'b1, '{1'b1, 24'hffffff, 32'hffaabbcc}},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hffaabbcc, 32'h00000000, 12'd1, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // Zero width clips everything.
    '{STEP_WRITE, CFG_DEST_X, 13'h0000, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_CANVAS_WIDTH, 13'd0, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hffaabbcc, 32'h00000000, 12'd0, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // A single-pixel canvas.
    '{STEP_WRITE, CFG_CANVAS_WIDTH, 13'd1, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_CANVAS_HEIGHT, 13'd1, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff010203, 32'h00000000, 12'd0, 12'd0},
      1'b1, '{1'b1, 24'd0, 32'hff010203}},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff010203, 32'h00000000, 12'd0, 12'd1},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // A write beyond the register list leaves the settings alone.
    '{STEP_WRITE, CfgIdxSpare, 13'h1fff, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff010203, 32'h00000000, 12'd0, 12'd0},
      1'b1, '{1'b1, 24'd0, 32'hff010203}},
    // Layer alpha of zero suppresses every write; upper data bits are dropped.
    '{STEP_WRITE, CFG_LAYER_ALPHA, 13'h1f00, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff010203, 32'h00000000, 12'd0, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    // Half layer alpha with the image shifted up by one row.
    '{STEP_WRITE, CFG_LAYER_ALPHA, 13'h0080, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_CANVAS_WIDTH, 13'd640, '0, 1'b0, '0},
    '{STEP_WRITE, CFG_DEST_Y, 13'h1fff, '0, 1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff204060, 32'h80808080, 12'd0, 12'd1},
      1'b0, '0},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'hff204060, 32'h80808080, 12'd0, 12'd0},
      1'b1, '{1'b0, 24'd0, 32'h0}},
    '{STEP_PIXEL, CFG_CANVAS_WIDTH, '0, '{32'h80c0e0f0, 32'h10203040, 12'd7, 12'd1},
      1'b0, '0}
  };

  // Canvas dimension as the block uses it: anything above the maximum is
  // treated as the maximum.
  function automatic int eff_dim(input logic [DimW-1:0] d);
    return (d > MaxCanvasDim) ? MaxCanvasDim : int'(d);
  endfunction

  // Expected result of one pixel under the current register settings.
  function automatic out_t blend_pixel(input in_t px);
    out_t res;
    int   w, h, dx, dy, col, row, tx, ty, a, over, below, s;
    res = '0;
    w   = eff_dim(canvas_w);
    h   = eff_dim(canvas_h);
    dx  = place_x;
    dy  = place_y;
    col = px.image_column;
    row = px.image_row;
    tx  = dx + col;
    ty  = dy + row;
    if (tx < 0 || ty < 0 || tx >= w || ty >= h) begin
      return res;
    end
    a = int'(px.source_pixel[31:24]) * int'(layer_a) / ChannelMax;
    if (a == 0) begin
      return res;
    end
    res.write_enable   = 1'b1;
    res.canvas_address = AddrW'(ty * w + tx);
    res.blended_pixel[31:24] = AlphaOpaque;
    for (s = 0; s < 3; s++) begin
      over  = px.source_pixel[8*s +: 8];
      below = px.canvas_pixel[8*s +: 8];
      res.blended_pixel[8*s +: 8] = 8'((over * a + below * (ChannelMax - a)) / ChannelMax);
    end
    return res;
  endfunction

  // Length of a gap or a stall: mostly none or short, now and then long.
  function automatic int idle_span();
    int r;
    if (steady_flow) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DimW'(1);
      2: return DimW'(MaxCanvasDim);
      3: return DimW'($urandom_range(MaxCanvasDim + 1, MaxDimWord));
      default: return DimW'($urandom_range(2, 700));
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DimW-1){1'b0}}};
      1: return {1'b0, {(DimW-1){1'b1}}};
      default: return DimW'($urandom_range(0, 128) - 64);
    endcase
  endfunction

  // Write one register through the configuration port and mirror it locally.
  task automatic program_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CANVAS_WIDTH:  canvas_w = val;
      CFG_CANVAS_HEIGHT: canvas_h = val;
      CFG_DEST_X:        place_x  = val;
      CFG_DEST_Y:        place_y  = val;
      CFG_LAYER_ALPHA:   layer_a  = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one pixel request after a random gap and hold it until it is taken.
  task automatic feed_pixel(input in_t px, input out_t want);
    int gap;
    gap = idle_span();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = px;
    do @(posedge clk_i); while (in_stall_o);
    pending_blends.push_back(want);
  endtask

  // Stop sending and let every owed result come out, then give the pipeline
  // its latency once more so it is certainly empty before a register write.
  task automatic drain_blender();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    while (pending_blends.size() != 0) @(posedge clk_i);
    repeat (PipeLatency) @(posedge clk_i);
  endtask

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Receiver: flowing stretches alternate with stalls of random length. Each
  // falling edge sees at most one change of the stall line.
  initial begin : receiver_stalls
    int n;
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      n = idle_span();
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Every result that leaves the block is matched against the oldest blend
  // still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_blends.size() == 0) begin
        $error("unexpected result request: %h", out_data_o);
        mismatches++;
      end else begin
        oldest_blend = pending_blends.pop_front();
        if (out_data_o.write_enable !== oldest_blend.write_enable) begin
          $error("write_enable: expected %0b, got %0b",
                 oldest_blend.write_enable, out_data_o.write_enable);
          mismatches++;
        end
        if (out_data_o.canvas_address !== oldest_blend.canvas_address) begin
          $error("canvas_address: expected %h, got %h",
                 oldest_blend.canvas_address, out_data_o.canvas_address);
          mismatches++;
        end
        if (out_data_o.blended_pixel !== oldest_blend.blended_pixel) begin
          $error("blended_pixel: expected %h, got %h",
                 oldest_blend.blended_pixel, out_data_o.blended_pixel);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                  i, phase, w, h, col, row;
    in_t                 px;
    logic [CfgDataW-1:0] reg_word;

    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_CANVAS_WIDTH;
    cfg_data_i   = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    steady_flow  = 1'b0;

    // Settings the block loads on reset.
    canvas_w = DimW'(640);
    canvas_h = DimW'(480);
    place_x  = '0;
    place_y  = '0;
    layer_a  = AlphaOpaque;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Register rows wait for the pipeline to empty first.
    for (i = 0; i < DirectedSteps; i++) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        drain_blender();
        program_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        feed_pixel(directed_steps[i].pixel,
                   directed_steps[i].typed ? directed_steps[i].result
                                           : blend_pixel(directed_steps[i].pixel));
      end
    end

    // Random phases, each with fresh settings. Every third phase runs with
    // no gaps or stalls at all, so the pipeline is also seen at full rate.
    for (phase = 0; phase < RandomPhases; phase++) begin
      drain_blender();
      steady_flow = (phase % 3 == 1);
      program_reg(CFG_CANVAS_WIDTH, pick_dim());
      program_reg(CFG_CANVAS_HEIGHT, pick_dim());
      program_reg(CFG_DEST_X, pick_offset());
      program_reg(CFG_DEST_Y, pick_offset());
      reg_word = CfgDataW'($urandom);
      case ($urandom_range(0, 5))
        0: reg_word[7:0] = 8'd0;
        1: reg_word[7:0] = AlphaOpaque;
        default: ;
      endcase
      program_reg(CFG_LAYER_ALPHA, reg_word);
      if ($urandom_range(0, 2) == 0) begin
        program_reg(CfgIdxW'($urandom_range(CfgIdxSpare, (1 << CfgIdxW) - 1)),
                    CfgDataW'($urandom));
      end

      w = eff_dim(canvas_w);
      h = eff_dim(canvas_h);
      repeat (ItemsPerPhase) begin
        px.source_pixel = $urandom;
        px.canvas_pixel = $urandom;
        case ($urandom_range(0, 4))
          0: px.source_pixel[31:24] = 8'd0;
          1: px.source_pixel[31:24] = AlphaOpaque;
          default: ;
        endcase
        // Most pixels are aimed at the visible canvas so that the blend path
        // is exercised; the rest land anywhere and mostly get clipped.
        if ($urandom_range(0, 3) != 0 && w > 0 && h > 0) begin
          col = int'($urandom_range(0, w - 1)) - int'(place_x);
          row = int'($urandom_range(0, h - 1)) - int'(place_y);
          if (col < 0 || col > MaxCoord) begin
            col = $urandom_range(0, MaxCoord);
          end
          if (row < 0 || row > MaxCoord) begin
            row = $urandom_range(0, MaxCoord);
          end
        end else begin
          col = $urandom_range(0, MaxCoord);
          row = $urandom_range(0, MaxCoord);
        end
        px.image_column = CoordW'(col);
        px.image_row    = CoordW'(row);
        feed_pixel(px, blend_pixel(px));
      end
    end

    drain_blender();
    repeat (2 * PipeLatency) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/cab_pkg.sv
design/cab_geom.sv
design/cab_blend.sv
design/clipped_alpha_blend.sv
sim/tb_clipped_alpha_blend.sv
